// ----- hdl/shared_interest_cluster_engine_core_defines.svh -----
// Assertion macros used by the checker file of the cluster engine.
`ifndef SHARED_INTEREST_CLUSTER_ENGINE_CORE_DEFINES_SVH
`define SHARED_INTEREST_CLUSTER_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SICE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define SICE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sice_pkg.sv -----
// Shared types and constants of the shared-interest cluster engine.
package sice_pkg;

  // Field widths of the item and result formats.
  localparam int PERSON_W   = 6;
  localparam int INTEREST_W = 10;
  localparam int SIZE_W     = 7;

  // Item kinds carried on the input tuser.
  localparam logic KIND_LINK   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Person count after reset.
  localparam logic [SIZE_W-1:0] COUNT_RESET = 7'd64;

  // One result item handed from the sequencer to the output register.
  typedef struct packed {
    logic              load;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] total;
    logic              last;
  } sice_emit_t;

endpackage

// ----- hdl/sice_engine.sv -----
// Sequencer and state memories of the cluster engine: find, union and sized report.
module sice_engine #(
  parameter int PERSONS   = 64,
  parameter int INTERESTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  logic                        kind_i,
  input  logic [sice_pkg::PERSON_W-1:0]   person_i,
  input  logic [sice_pkg::INTEREST_W-1:0] interest_i,
  input  logic [sice_pkg::SIZE_W-1:0]     count_i,
  input  logic                        out_free_i,
  output logic                        idle_o,
  output sice_pkg::sice_emit_t        emit_o
);
  import sice_pkg::*;

  localparam int HOLD_DEPTH = (INTERESTS < (1 << INTEREST_W)) ? INTERESTS : (1 << INTEREST_W);
  localparam int PW         = $clog2(PERSONS);
  localparam int HAW        = $clog2(HOLD_DEPTH);
  localparam int CLR_LEN    = (HOLD_DEPTH > PERSONS) ? HOLD_DEPTH : PERSONS;
  localparam int CW         = $clog2(CLR_LEN);
  localparam int CLW        = CW + 1;

  typedef enum logic [11:0] {
    ST_CLEAR = 12'b0000_0000_0001,
    ST_IDLE  = 12'b0000_0000_0010,
    ST_DISP  = 12'b0000_0000_0100,
    ST_HCHK  = 12'b0000_0000_1000,
    ST_W1    = 12'b0000_0001_0000,
    ST_W2    = 12'b0000_0010_0000,
    ST_SZA   = 12'b0000_0100_0000,
    ST_SZB   = 12'b0000_1000_0000,
    ST_RP    = 12'b0001_0000_0000,
    ST_RH    = 12'b0010_0000_0000,
    ST_EC    = 12'b0100_0000_0000,
    ST_EO    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;

  // Captured item.
  logic                  kind_q, kind_d;
  logic [PERSON_W-1:0]   person_q, person_d;
  logic [INTEREST_W-1:0] interest_q, interest_d;

  // Walk and union registers.
  logic [PW-1:0]     cur_q, cur_d;
  logic [PW-1:0]     r1_q, r1_d;
  logic [PW-1:0]     r2_q, r2_d;
  logic [SIZE_W-1:0] sa_q, sa_d;

  // Report registers.
  logic [PW-1:0]     scan_q, scan_d;
  logic [PW-1:0]     hidx_q, hidx_d;
  logic [PW-1:0]     esz_q, esz_d;
  logic [SIZE_W-1:0] roots_q, roots_d;
  logic [SIZE_W-1:0] sent_q, sent_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;

  // Memories and their ports.
  logic [PW-1:0]     par_mem [PERSONS];
  logic [SIZE_W-1:0] siz_mem [PERSONS];
  logic [PW:0]       hld_mem [HOLD_DEPTH];
  logic [SIZE_W-1:0] hst_mem [PERSONS];

  logic              par_we, siz_we, hld_we, hst_we;
  logic [PW-1:0]     par_waddr, par_wdata, par_raddr, par_rd_q;
  logic [PW-1:0]     siz_waddr, siz_raddr;
  logic [SIZE_W-1:0] siz_wdata, siz_rd_q;
  logic [HAW-1:0]    hld_waddr, hld_raddr;
  logic [PW:0]       hld_wdata, hld_rd_q;
  logic [PW-1:0]     hst_waddr, hst_raddr;
  logic [SIZE_W-1:0] hst_wdata, hst_rd_q;

  logic [PW-1:0]     person_idx;
  logic [PW-1:0]     holder;
  logic [PW-1:0]     last_idx;
  logic              person_ok, interest_ok;
  logic [SIZE_W-1:0] sent_inc;

  assign person_idx  = person_q[PW-1:0];
  assign last_idx    = PW'(count_i - SIZE_W'(1));
  assign person_ok   = ({1'b0, person_q} < count_i);
  assign interest_ok = (int'(interest_q) < INTERESTS);
  assign holder      = hld_rd_q[PW] ? hld_rd_q[PW-1:0] : person_idx;
  assign sent_inc    = sent_q + SIZE_W'(1);
  assign idle_o      = (state_q == ST_IDLE);

  // Sequencer: one step of a parent walk per cycle; the root scan spends an extra state on each root.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    kind_d     = kind_q;
    person_d   = person_q;
    interest_d = interest_q;
    cur_d      = cur_q;
    r1_d       = r1_q;
    r2_d       = r2_q;
    sa_d       = sa_q;
    scan_d     = scan_q;
    hidx_d     = hidx_q;
    esz_d      = esz_q;
    roots_d    = roots_q;
    sent_d     = sent_q;
    cnt_d      = cnt_q;
    par_we     = 1'b0;
    par_waddr  = '0;
    par_wdata  = '0;
    par_raddr  = '0;
    siz_we     = 1'b0;
    siz_waddr  = '0;
    siz_wdata  = '0;
    siz_raddr  = '0;
    hld_we     = 1'b0;
    hld_waddr  = '0;
    hld_wdata  = '0;
    hld_raddr  = interest_q[HAW-1:0];
    hst_we     = 1'b0;
    hst_waddr  = '0;
    hst_wdata  = '0;
    hst_raddr  = '0;
    emit_o     = '0;

    case (state_q)
      ST_CLEAR: begin
        // Initialize every store, one address per cycle.
        par_we    = ({1'b0, clr_q} < CLW'(PERSONS));
        par_waddr = clr_q[PW-1:0];
        par_wdata = clr_q[PW-1:0];
        siz_we    = par_we;
        siz_waddr = clr_q[PW-1:0];
        siz_wdata = SIZE_W'(1);
        hst_we    = par_we;
        hst_waddr = clr_q[PW-1:0];
        hld_we    = ({1'b0, clr_q} < CLW'(HOLD_DEPTH));
        hld_waddr = clr_q[HAW-1:0];
        if (clr_q == CW'(CLR_LEN - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + CW'(1);
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          kind_d     = kind_i;
          person_d   = person_i;
          interest_d = interest_i;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        if (kind_q == KIND_REPORT) begin
          // Start the root scan at person zero.
          scan_d    = '0;
          roots_d   = '0;
          sent_d    = '0;
          par_raddr = '0;
          siz_raddr = '0;
          state_d   = ST_RP;
        end else if (person_ok && interest_ok) begin
          state_d = ST_HCHK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_HCHK: begin
        // Claim the interest if nobody holds it yet, then walk from the holder.
        if (!hld_rd_q[PW]) begin
          hld_we    = 1'b1;
          hld_waddr = interest_q[HAW-1:0];
          hld_wdata = {1'b1, person_idx};
        end
        cur_d     = holder;
        par_raddr = holder;
        state_d   = ST_W1;
      end
      ST_W1: begin
        if (par_rd_q == cur_q) begin
          r1_d      = cur_q;
          cur_d     = person_idx;
          par_raddr = person_idx;
          state_d   = ST_W2;
        end else begin
          cur_d     = par_rd_q;
          par_raddr = par_rd_q;
        end
      end
      ST_W2: begin
        if (par_rd_q == cur_q) begin
          if (cur_q == r1_q) begin
            state_d = ST_IDLE;
          end else begin
            r2_d      = cur_q;
            siz_raddr = r1_q;
            state_d   = ST_SZA;
          end
        end else begin
          cur_d     = par_rd_q;
          par_raddr = par_rd_q;
        end
      end
      ST_SZA: begin
        sa_d      = siz_rd_q;
        siz_raddr = r2_q;
        state_d   = ST_SZB;
      end
      ST_SZB: begin
        // Hang the person's root under the holder's root and add the sizes.
        siz_we    = 1'b1;
        siz_waddr = r1_q;
        siz_wdata = sa_q + siz_rd_q;
        par_we    = 1'b1;
        par_waddr = r2_q;
        par_wdata = r1_q;
        state_d   = ST_IDLE;
      end
      ST_RP: begin
        // A root's size bumps its histogram bin; others are skipped.
        if (par_rd_q == scan_q) begin
          hidx_d    = PW'(siz_rd_q - SIZE_W'(1));
          hst_raddr = PW'(siz_rd_q - SIZE_W'(1));
          roots_d   = roots_q + SIZE_W'(1);
          state_d   = ST_RH;
        end else if (scan_q == last_idx) begin
          esz_d     = PW'(PERSONS - 1);
          hst_raddr = PW'(PERSONS - 1);
          state_d   = (roots_q == '0) ? ST_IDLE : ST_EC;
        end else begin
          scan_d    = scan_q + PW'(1);
          par_raddr = scan_q + PW'(1);
          siz_raddr = scan_q + PW'(1);
        end
      end
      ST_RH: begin
        hst_we    = 1'b1;
        hst_waddr = hidx_q;
        hst_wdata = hst_rd_q + SIZE_W'(1);
        if (scan_q == last_idx) begin
          esz_d = PW'(PERSONS - 1);
          if (hidx_q == PW'(PERSONS - 1)) begin
            // The top bin is bumped in this cycle, so it cannot be read back yet:
            // take its count straight into the result loop and leave the bin clear.
            hst_wdata = '0;
            cnt_d     = hst_rd_q + SIZE_W'(1);
            state_d   = ST_EO;
          end else begin
            hst_raddr = PW'(PERSONS - 1);
            state_d   = ST_EC;
          end
        end else begin
          scan_d    = scan_q + PW'(1);
          par_raddr = scan_q + PW'(1);
          siz_raddr = scan_q + PW'(1);
          state_d   = ST_RP;
        end
      end
      ST_EC: begin
        // Take a bin's count and clear the bin for the next report.
        hst_we    = 1'b1;
        hst_waddr = esz_q;
        if (hst_rd_q == '0) begin
          esz_d     = esz_q - PW'(1);
          hst_raddr = esz_q - PW'(1);
        end else begin
          cnt_d   = hst_rd_q;
          state_d = ST_EO;
        end
      end
      ST_EO: begin
        if (out_free_i) begin
          emit_o.load  = 1'b1;
          emit_o.size  = SIZE_W'(esz_q) + SIZE_W'(1);
          emit_o.total = roots_q;
          emit_o.last  = (sent_inc == roots_q);
          sent_d       = sent_inc;
          cnt_d        = cnt_q - SIZE_W'(1);
          if (sent_inc == roots_q) begin
            state_d = ST_IDLE;
          end else if (cnt_q == SIZE_W'(1)) begin
            esz_d     = esz_q - PW'(1);
            hst_raddr = esz_q - PW'(1);
            state_d   = ST_EC;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Working registers, always loaded before they are used.
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    person_q   <= person_d;
    interest_q <= interest_d;
    cur_q      <= cur_d;
    r1_q       <= r1_d;
    r2_q       <= r2_d;
    sa_q       <= sa_d;
    scan_q     <= scan_d;
    hidx_q     <= hidx_d;
    esz_q      <= esz_d;
    roots_q    <= roots_d;
    sent_q     <= sent_d;
    cnt_q      <= cnt_d;
  end

  // Parent links.
  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rd_q <= par_mem[par_raddr];
  end

  // Set sizes, meaningful at roots only.
  always_ff @(posedge clk_i) begin
    if (siz_we) begin
      siz_mem[siz_waddr] <= siz_wdata;
    end
    siz_rd_q <= siz_mem[siz_raddr];
  end

  // First holder of each interest: valid bit over the person index.
  always_ff @(posedge clk_i) begin
    if (hld_we) begin
      hld_mem[hld_waddr] <= hld_wdata;
    end
    hld_rd_q <= hld_mem[hld_raddr];
  end

  // Histogram of root sizes, indexed by size minus one.
  always_ff @(posedge clk_i) begin
    if (hst_we) begin
      hst_mem[hst_waddr] <= hst_wdata;
    end
    hst_rd_q <= hst_mem[hst_raddr];
  end

endmodule

// ----- hdl/shared_interest_cluster_engine_core.sv -----
// Top level of the shared-interest cluster engine: ports, count register, result register.
//
// Channel   Direction  Handshake                        Contents
// s_axis    in         s_axis_tvalid / s_axis_tready    tuser kind, tdata person, interest
// m_axis    out        m_axis_tvalid / m_axis_tready    tdata size, total; tlast
// cfg       in         cfg_wr_en_i                      person_count
//
// After reset the block sweeps every address of its stores and takes no item meanwhile;
// count writes are taken at any time. A valid link is captured and checked, walks up the
// parent chains of the interest's holder and of the person and, if the roots differ, reads
// both root sizes and joins them. A report scans every person and bumps the bin of each root,
// then walks the histogram down from the largest size and emits one result per root.
// A stalled result sits in the output register and holds the report sequencer; once the
// last result is loaded, the next item is taken while it waits.
module shared_interest_cluster_engine_core #(
  parameter int PERSONS   = 64,
  parameter int INTERESTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [6:0]  cfg_wr_data_i,   // person_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // person [5:0], interest [15:6]
  input  logic        s_axis_tuser,    // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // cluster_size [6:0], cluster_total [13:7], zero [15:14]
  output logic        m_axis_tlast     // last
);
  import sice_pkg::*;

  logic [SIZE_W-1:0] count_cfg_q;
  logic [SIZE_W-1:0] count_eff;
  logic              idle;
  logic              out_free;
  sice_emit_t        emit;

  logic              out_valid_q;
  logic [SIZE_W-1:0] out_size_q;
  logic [SIZE_W-1:0] out_total_q;
  logic              out_last_q;

  // Person count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_cfg_q <= COUNT_RESET;
    end else if (cfg_wr_en_i) begin
      count_cfg_q <= cfg_wr_data_i;
    end
  end

  // Zero counts as one person; anything above the array counts as all of it.
  always_comb begin
    if (count_cfg_q == '0) begin
      count_eff = SIZE_W'(1);
    end else if (int'(count_cfg_q) > PERSONS) begin
      count_eff = SIZE_W'(PERSONS);
    end else begin
      count_eff = count_cfg_q;
    end
  end

  sice_engine #(
    .PERSONS   (PERSONS),
    .INTERESTS (INTERESTS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid && idle),
    .kind_i       (s_axis_tuser),
    .person_i     (s_axis_tdata[PERSON_W-1:0]),
    .interest_i   (s_axis_tdata[PERSON_W+INTEREST_W-1:PERSON_W]),
    .count_i      (count_eff),
    .out_free_i   (out_free),
    .idle_o       (idle),
    .emit_o       (emit)
  );

  assign s_axis_tready = idle;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_size_q  <= emit.size;
      out_total_q <= emit.total;
      out_last_q  <= emit.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_total_q, out_size_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- hdl/sice_checker.sv -----
// Port-level checks of the cluster engine and their binding to the top level.
`include "shared_interest_cluster_engine_core_defines.svh"

module sice_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result keeps its value and its last mark.
  `SICE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // Every item keeps the engine busy for at least the following cycle.
  `SICE_ASSERT_NXT(a_busy_after_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after an accepted item")

  // A report is not finished while a result other than its last is on the port.
  `SICE_ASSERT_IMP(a_busy_mid_report, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "ready in the middle of a report")

  // Sizes and totals are never zero, and the padding bits stay clear.
  `SICE_ASSERT_IMP(a_out_fields, m_axis_tvalid, (m_axis_tdata[6:0] != 7'd0) && (m_axis_tdata[13:7] != 7'd0) && (m_axis_tdata[15:14] == 2'b00), "bad result fields")

endmodule

bind shared_interest_cluster_engine_core sice_checker u_sice_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking testbench for the shared-interest cluster engine core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sice_pkg::*;

  localparam int PERSON_MAX    = 64;
  localparam int INTEREST_MAX  = 1024;
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 50;
  localparam int DIR_ROWS      = 23;

  // One cluster size as it leaves the block.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] total;
    logic              last;
  } cluster_result_t;

  // One row of the directed stimulus; known rows carry a uniform report answer.
  typedef struct packed {
    logic                  kind;
    logic [PERSON_W-1:0]   person;
    logic [INTEREST_W-1:0] interest;
    logic                  known;
    logic [SIZE_W-1:0]     known_size;
    logic [SIZE_W-1:0]     known_total;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_wr_en_i   = 1'b0;
  logic [6:0]  cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // person [5:0], interest [15:6]
  logic        s_axis_tuser  = 1'b0; // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // cluster_size [6:0], cluster_total [13:7]
  logic        m_axis_tlast;         // last

  // Predictor state: forest of persons, first holder per interest, count register.
  logic [PERSON_W-1:0] parent_tab [PERSON_MAX];
  logic [SIZE_W-1:0]   size_tab   [PERSON_MAX];
  logic                holder_ok  [INTEREST_MAX];
  logic [PERSON_W-1:0] holder_id  [INTEREST_MAX];
  logic [SIZE_W-1:0]   count_reg;

  cluster_result_t pending_sizes [$];
  dir_row_t        dir_table [DIR_ROWS];
  int              mismatch_count = 0;
  int              send_idle_pct  = 0;
  int              recv_idle_pct  = 0;

  shared_interest_cluster_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Effective person count: zero acts as one, anything above the array size saturates.
  function automatic int live_persons();
    if (count_reg == 0) return 1;
    if (int'(count_reg) > PERSON_MAX) return PERSON_MAX;
    return int'(count_reg);
  endfunction

  function automatic int find_root(input int start);
    int node;
    node = start;
    for (int step = 0; step < PERSON_MAX; step++) begin
      if (int'(parent_tab[node]) == node) break;
      node = int'(parent_tab[node]);
    end
    return node;
  endfunction

  function automatic void clear_forest();
    for (int p = 0; p < PERSON_MAX; p++) begin
      parent_tab[p] = PERSON_W'(p);
      size_tab[p]   = SIZE_W'(1);
    end
    for (int i = 0; i < INTEREST_MAX; i++) begin
      holder_ok[i] = 1'b0;
      holder_id[i] = '0;
    end
    count_reg = COUNT_RESET;
  endfunction

  // A link attaches the person's root under the root of the interest's first holder.
  function automatic void merge_interest_link(input logic [PERSON_W-1:0] person,
                                              input logic [INTEREST_W-1:0] interest);
    int r_hold, r_pers;
    if (int'(person) >= live_persons()) return;
    if (!holder_ok[interest]) begin
      holder_ok[interest] = 1'b1;
      holder_id[interest] = person;
    end
    r_hold = find_root(int'(holder_id[interest]));
    r_pers = find_root(int'(person));
    if (r_hold != r_pers) begin
      size_tab[r_hold]   = size_tab[r_hold] + size_tab[r_pers];
      size_tab[r_pers]   = '0;
      parent_tab[r_pers] = PERSON_W'(r_hold);
    end
  endfunction

  // A report lists root sizes below the count, largest first.
  function automatic void rank_cluster_sizes();
    int ranked [PERSON_MAX];
    int roots, slot;
    cluster_result_t res;
    roots = 0;
    for (int p = 0; p < live_persons(); p++) begin
      if (int'(parent_tab[p]) == p) begin
        slot = roots;
        while (slot > 0 && ranked[slot-1] < int'(size_tab[p])) begin
          ranked[slot] = ranked[slot-1];
          slot--;
        end
        ranked[slot] = int'(size_tab[p]);
        roots++;
      end
    end
    for (int k = 0; k < roots; k++) begin
      res.size  = SIZE_W'(ranked[k]);
      res.total = SIZE_W'(roots);
      res.last  = (k == roots - 1);
      pending_sizes.push_back(res);
    end
  endfunction

  function automatic void predict_item(input logic kind, input logic [PERSON_W-1:0] person,
                                       input logic [INTEREST_W-1:0] interest);
    if (kind == KIND_REPORT) rank_cluster_sizes();
    else merge_interest_link(person, interest);
  endfunction

  // Present one item, with an optional idle gap first, and return at its accepting edge.
  task automatic push_item(input logic kind, input logic [PERSON_W-1:0] person,
                           input logic [INTEREST_W-1:0] interest);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {interest, person};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold the sender until every expected size has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_sizes.size() != 0);
  endtask

  // Count writes only with the block idle; links leave no result to wait on.
  task automatic write_count(input logic [6:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    count_reg = value;
  endtask

  // Receiver: random back-pressure and comparison against the oldest expected size.
  always @(posedge clk_i) begin
    cluster_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_sizes.size() == 0) begin
          $display("%0t unexpected result: expected none, actual size %0d total %0d last %0b",
                   $time, m_axis_tdata[6:0], m_axis_tdata[13:7], m_axis_tlast);
          mismatch_count++;
        end else begin
          want = pending_sizes.pop_front();
          if (m_axis_tdata[6:0] !== want.size) begin
            $display("%0t cluster_size mismatch: expected %0d, actual %0d",
                     $time, want.size, m_axis_tdata[6:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[13:7] !== want.total) begin
            $display("%0t cluster_total mismatch: expected %0d, actual %0d",
                     $time, want.total, m_axis_tdata[13:7]);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t last mismatch: expected %0b, actual %0b",
                     $time, want.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [6:0]            phase_counts [PHASES];
    cluster_result_t       fixed_res;
    logic                  kind;
    logic [PERSON_W-1:0]   person;
    logic [INTEREST_W-1:0] interest;
    int                    pick, base, counted;

    clear_forest();
    // Fresh state, duplicates, a merge of two clusters, a parent chain, alternating bits.
    dir_table = '{
      '{KIND_REPORT, 6'd0,  10'd0,    1'b1, 7'd1, 7'd64},
      '{KIND_LINK,   6'd0,  10'd0,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd0,  10'd0,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd63, 10'd1023, 1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd1,  10'd0,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd2,  10'd1023, 1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd2,  10'd0,    1'b0, 7'd0, 7'd0},
      '{KIND_REPORT, 6'd63, 10'd1023, 1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd3,  10'd5,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd4,  10'd6,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd3,  10'd6,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd5,  10'd7,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd4,  10'd7,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd6,  10'd8,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd5,  10'd8,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd1,  10'd8,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd7,  10'd682,  1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd21, 10'd682,  1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd42, 10'd341,  1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd3,  10'd341,  1'b0, 7'd0, 7'd0},
      '{KIND_REPORT, 6'd0,  10'd0,    1'b0, 7'd0, 7'd0},
      '{KIND_LINK,   6'd63, 10'd0,    1'b0, 7'd0, 7'd0},
      '{KIND_REPORT, 6'd21, 10'd682,  1'b0, 7'd0, 7'd0}
    };
    // Count settings per random phase: above the range, small, zero, one, full, random.
    phase_counts = '{7'd127, 7'd5, 7'd0, 7'd1, 7'd64, 7'(($urandom_range(62, 2)))};

    send_idle_pct = 25;
    recv_idle_pct = 56;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows.
    for (int r = 0; r < DIR_ROWS; r++) begin
      push_item(dir_table[r].kind, dir_table[r].person, dir_table[r].interest);
      if (dir_table[r].known) begin
        for (int k = 0; k < int'(dir_table[r].known_total); k++) begin
          fixed_res.size  = dir_table[r].known_size;
          fixed_res.total = dir_table[r].known_total;
          fixed_res.last  = (k == int'(dir_table[r].known_total) - 1);
          pending_sizes.push_back(fixed_res);
        end
      end else begin
        predict_item(dir_table[r].kind, dir_table[r].person, dir_table[r].interest);
      end
    end

    // Random phases, each under its own count setting; the idle profile changes every two phases.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 56;
        recv_idle_pct = 25;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_count(phase_counts[ph]);
      base    = $urandom_range(INTEREST_MAX - 12, 0);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 18) begin
          kind     = KIND_REPORT;
          person   = PERSON_W'($urandom);
          interest = INTEREST_W'($urandom);
        end else if (pick < 28) begin
          // Noise: any person, any interest.
          kind     = KIND_LINK;
          person   = PERSON_W'($urandom);
          interest = INTEREST_W'($urandom);
        end else begin
          // Well-formed link, mostly on a narrow window of interests so clusters grow.
          kind   = KIND_LINK;
          person = PERSON_W'($urandom_range(live_persons() - 1, 0));
          if ($urandom_range(99) < 60) interest = INTEREST_W'(base + $urandom_range(11, 0));
          else interest = INTEREST_W'($urandom);
        end
        push_item(kind, person, interest);
        if (kind == KIND_REPORT || int'(person) < live_persons()) counted++;
        predict_item(kind, person, interest);
        if ($urandom_range(99) < 4) drain_results();
      end
    end

    // Let every expected size come out, then allow for trailing work.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/sice_pkg.sv
hdl/sice_engine.sv
hdl/shared_interest_cluster_engine_core.sv
hdl/sice_checker.sv
bench/testbench.sv
